@@ rtl/core/buddy_page_allocator_assert.svh @@
// assertion macros for the buddy page allocator checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bpa_pkg.sv @@
// shared types and constants of the buddy page allocator
// used by the controller, the datapath, the top level and the checker
package bpa_pkg;

  localparam int PageCount  = 4096;
  localparam int PageW      = 12;
  localparam int OrderCount = 6;
  localparam int OrdW       = 3;
  localparam int CntW       = 13;
  localparam int SwW        = OrderCount - 1;
  localparam int CfgIdxW    = 1;

  localparam logic [OrdW-1:0] NotHead  = 3'd7;
  localparam logic [CntW-1:0] TotalMax = 13'd8191;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_KERNEL = 2'd2,
    ST_BAD    = 2'd3
  } status_e;

  typedef enum logic {
    CFG_KERNEL_FIRST = 1'b0,
    CFG_KERNEL_END   = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_REPORT, CMD_ALLOC_INIT, CMD_RD_TAIL,
    CMD_RD_XLINK, CMD_UNLINK, CMD_SPLIT_ORD_P, CMD_SPLIT_ORD_B, CMD_SPLIT_PUSH_P,
    CMD_SPLIT_PUSH_B, CMD_GRANT, CMD_RD_CUR, CMD_SWEEP, CMD_RD_BUDDY,
    CMD_MERGE_B, CMD_MERGE_C, CMD_FREE_FIN, CMD_FREE_PUSH
  } cmd_e;

  typedef struct packed {
    logic                opcode;
    logic [PageW-1:0]    page_idx;
    logic [OrdW-1:0]     block_order;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [PageW-1:0]    granted_page;
    logic [CntW-1:0]     free_page_total;
  } rsp_t;

  typedef struct packed {
    cmd_e    op;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic bad_order;
    logic none_free;
    logic range_bad;
    logic kernel_hit;
    logic cur_taken;
    logic sweep_last;
    logic k_gt_o;
    logic k_lt_top;
    logic buddy_ok;
  } dp_sts_t;

endpackage

@@ rtl/core/buddy_page_allocator.sv @@
// top level of the buddy page allocator
// depends on bpa_pkg, bpa_ctrl and bpa_dp
//
// usage
// - command channel: start with req_i is taken at a clock edge where busy is
//   low; opcode 0 allocates a block of 2**block_order pages, 1 frees one
// - one result item per command on rsp_o, flagged by result_valid_o for a
//   single cycle; the receiver cannot stall it, so it must sample it then
// - configuration channel: cfg_valid_i with cfg_index_i and cfg_data_i;
//   cfg_ready_o is always high, index 0 is the first kernel page, index 1
//   the page just past the kernel range; write only while idle
// - an allocation unlinks a free block and splits it down one order at a
//   time; a free sweeps every page of the block, then merges with free
//   buddies up to the top order; bad order, out of memory, out of range,
//   kernel rejects and a free of a page that is already a free head are
//   reported without touching the lists; the single-port page tables and
//   the linked-list memories serialise these steps
// - busy stays high from accept until the result cycle, and a new command
//   may be given in the cycle its result shows
// - after reset a clearing pass marks every page as not a free head and
//   not valid; busy is high throughout, config is still taken
module buddy_page_allocator import bpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  req_t               req_i,
  output logic               result_valid_o,
  output rsp_t               rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CntW-1:0]    cfg_data_i
);

  cmd_t    cmd;
  dp_sts_t sts;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  // sequencer: accepts commands and steps through split and merge chains
  bpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // datapath: memories, free lists, totals and the result register
  bpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sts_o       (sts),
    .rvalid_o    (result_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

@@ rtl/core/bpa_ctrl.sv @@
// sequencer of the buddy page allocator
// depends on bpa_pkg; drives bpa_dp through cmd_t and reads dp_sts_t
module bpa_ctrl import bpa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  dp_sts_t sts_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_CLEAR    = 18'h00002,
    S_DECODE   = 18'h00004,
    S_A_CHECK  = 18'h00008,
    S_A_UNLINK = 18'h00010,
    S_A_OP     = 18'h00020,
    S_A_OB     = 18'h00040,
    S_A_PP     = 18'h00080,
    S_A_PB     = 18'h00100,
    S_A_GRANT  = 18'h00200,
    S_F_HEAD   = 18'h00400,
    S_F_SWEEP  = 18'h00800,
    S_F_TEST   = 18'h01000,
    S_F_BCHK   = 18'h02000,
    S_F_UNLINK = 18'h04000,
    S_F_MB     = 18'h08000,
    S_F_MC     = 18'h10000,
    S_F_PUSH   = 18'h20000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = CMD_NONE;
    cmd_o.code  = ST_OK;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = CMD_CLEAR;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.bad_order) begin
          cmd_o.op = CMD_REPORT; cmd_o.code = ST_BAD; state_d = S_IDLE;
        end else if (!sts_i.is_free) begin
          if (sts_i.none_free) begin
            cmd_o.op = CMD_REPORT; cmd_o.code = ST_NOMEM; state_d = S_IDLE;
          end else begin
            cmd_o.op = CMD_ALLOC_INIT; state_d = S_A_CHECK;
          end
        end else if (sts_i.range_bad) begin
          cmd_o.op = CMD_REPORT; cmd_o.code = ST_BAD; state_d = S_IDLE;
        end else if (sts_i.kernel_hit) begin
          cmd_o.op = CMD_REPORT; cmd_o.code = ST_KERNEL; state_d = S_IDLE;
        end else begin
          cmd_o.op = CMD_RD_CUR; state_d = S_F_HEAD;
        end
      end
      S_A_CHECK: begin
        cmd_o.op = CMD_RD_TAIL; state_d = S_A_UNLINK;
      end
      S_A_UNLINK: begin
        cmd_o.op = CMD_UNLINK;
        state_d  = sts_i.k_gt_o ? S_A_OP : S_A_GRANT;
      end
      S_A_OP: begin
        cmd_o.op = CMD_SPLIT_ORD_P; state_d = S_A_OB;
      end
      S_A_OB: begin
        cmd_o.op = CMD_SPLIT_ORD_B; state_d = S_A_PP;
      end
      S_A_PP: begin
        cmd_o.op = CMD_SPLIT_PUSH_P; state_d = S_A_PB;
      end
      S_A_PB: begin
        cmd_o.op = CMD_SPLIT_PUSH_B; state_d = S_A_CHECK;
      end
      S_A_GRANT: begin
        cmd_o.op = CMD_GRANT; state_d = S_IDLE;
      end
      S_F_HEAD: begin
        if (sts_i.cur_taken) begin
          cmd_o.op = CMD_REPORT; cmd_o.code = ST_BAD; state_d = S_IDLE;
        end else begin
          state_d = S_F_SWEEP;
        end
      end
      S_F_SWEEP: begin
        cmd_o.op = CMD_SWEEP;
        if (sts_i.sweep_last) state_d = S_F_TEST;
      end
      S_F_TEST: begin
        if (sts_i.k_lt_top) begin
          cmd_o.op = CMD_RD_BUDDY; state_d = S_F_BCHK;
        end else begin
          cmd_o.op = CMD_FREE_FIN; state_d = S_F_PUSH;
        end
      end
      S_F_BCHK: begin
        if (sts_i.buddy_ok) begin
          cmd_o.op = CMD_RD_XLINK; state_d = S_F_UNLINK;
        end else begin
          cmd_o.op = CMD_FREE_FIN; state_d = S_F_PUSH;
        end
      end
      S_F_UNLINK: begin
        cmd_o.op = CMD_UNLINK; state_d = S_F_MB;
      end
      S_F_MB: begin
        cmd_o.op = CMD_MERGE_B; state_d = S_F_MC;
      end
      S_F_MC: begin
        cmd_o.op = CMD_MERGE_C; state_d = S_F_TEST;
      end
      S_F_PUSH: begin
        cmd_o.op = CMD_FREE_PUSH; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/bpa_dp.sv @@
// datapath of the buddy page allocator: page tables, links, lists, totals
// depends on bpa_pkg; executes the cmd_t issued by bpa_ctrl
module bpa_dp import bpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  req_t               req_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CntW-1:0]    cfg_data_i,
  output dp_sts_t            sts_o,
  output logic               rvalid_o,
  output rsp_t               rsp_o
);

  // page tables and links
  logic [OrdW-1:0]  ord_mem  [PageCount];
  logic             vld_mem  [PageCount];
  logic [PageW-1:0] next_mem [PageCount];
  logic [PageW-1:0] prev_mem [PageCount];

  logic [PageW-1:0] head_q [OrderCount];
  logic [PageW-1:0] tail_q [OrderCount];
  logic [CntW-1:0]  len_q  [OrderCount];

  logic             op_q;
  logic [OrdW-1:0]  ord_q, k_q;
  logic [PageW-1:0] cur_q, x_q, clr_q;
  logic [SwW-1:0]   sweep_q;
  logic [CntW-1:0]  total_q, kfirst_q, kend_q;
  logic             rvalid_q;
  rsp_t             rsp_q;

  logic [OrdW-1:0]  ord_rd_q;
  logic             vld_rd_q;
  logic [PageW-1:0] next_rd_q, prev_rd_q;

  // memory port controls
  logic             ord_we, ord_re, vld_we, vld_re, lnk_re, next_we, prev_we;
  logic [PageW-1:0] ord_a, vld_a, lnk_a, next_a, prev_a, next_wd, prev_wd;
  logic [OrdW-1:0]  ord_wd;
  logic             vld_wd;

  logic [PageW-1:0] size, bit_k, buddy, push_pg;
  logic [CntW-1:0]  size13, total_sub, total_add;
  logic [CntW:0]    sum14;
  logic [OrdW-1:0]  srch;
  logic             found;

  assign size   = PageW'(1) << ord_q;
  assign size13 = CntW'(1) << ord_q;
  assign bit_k  = PageW'(1) << k_q;
  assign buddy  = cur_q ^ bit_k;

  // lowest non-empty order at or above the request
  always_comb begin
    srch  = '0;
    found = 1'b0;
    for (int i = OrderCount - 1; i >= 0; i--) begin
      if (OrdW'(i) >= ord_q && len_q[i] != '0) begin
        srch  = OrdW'(i);
        found = 1'b1;
      end
    end
  end

  assign total_sub = (total_q >= size13) ? total_q - size13 : '0;
  assign sum14     = {1'b0, total_q} + {1'b0, size13};
  assign total_add = (sum14 > {1'b0, TotalMax}) ? TotalMax : sum14[CntW-1:0];

  always_comb begin
    sts_o.clear_last = (clr_q == PageW'(PageCount - 1));
    sts_o.is_free    = op_q;
    sts_o.bad_order  = (ord_q >= OrdW'(OrderCount));
    sts_o.none_free  = !found;
    sts_o.range_bad  = (({1'b0, cur_q} + size13) > CntW'(PageCount));
    sts_o.kernel_hit = ({1'b0, cur_q} >= kfirst_q) && ({1'b0, cur_q} < kend_q);
    sts_o.cur_taken  = (ord_rd_q != NotHead);
    sts_o.sweep_last = (sweep_q == SwW'(size - PageW'(1)));
    sts_o.k_gt_o     = (k_q > ord_q);
    sts_o.k_lt_top   = (k_q < OrdW'(OrderCount - 1));
    sts_o.buddy_ok   = (ord_rd_q == k_q) && vld_rd_q;
  end

  assign push_pg = (cmd_i.op == CMD_SPLIT_PUSH_B) ? (x_q ^ bit_k) :
                   (cmd_i.op == CMD_FREE_PUSH)    ? cur_q : x_q;

  always_comb begin
    ord_we = 1'b0; ord_re = 1'b0; ord_a = cur_q; ord_wd = NotHead;
    vld_we = 1'b0; vld_re = 1'b0; vld_a = cur_q; vld_wd = 1'b0;
    lnk_re = 1'b0; lnk_a = x_q;
    next_we = 1'b0; next_a = x_q; next_wd = '0;
    prev_we = 1'b0; prev_a = x_q; prev_wd = '0;
    case (cmd_i.op)
      CMD_CLEAR: begin
        ord_we = 1'b1; ord_a = clr_q;
        vld_we = 1'b1; vld_a = clr_q;
      end
      CMD_RD_CUR:  ord_re = 1'b1;
      CMD_SWEEP: begin
        vld_we = 1'b1; vld_a = cur_q | PageW'(sweep_q); vld_wd = 1'b1;
      end
      CMD_RD_BUDDY: begin
        ord_re = 1'b1; ord_a = buddy;
        vld_re = 1'b1; vld_a = buddy;
      end
      CMD_RD_TAIL: begin
        lnk_re = 1'b1; lnk_a = tail_q[k_q];
      end
      CMD_RD_XLINK: lnk_re = 1'b1;
      CMD_UNLINK: begin
        if (x_q != head_q[k_q]) begin
          next_we = 1'b1; next_a = prev_rd_q; next_wd = next_rd_q;
        end
        if (x_q != tail_q[k_q]) begin
          prev_we = 1'b1; prev_a = next_rd_q; prev_wd = prev_rd_q;
        end
      end
      CMD_SPLIT_ORD_P: begin
        ord_we = 1'b1; ord_a = x_q; ord_wd = k_q - OrdW'(1);
      end
      CMD_SPLIT_ORD_B: begin
        ord_we = 1'b1; ord_a = x_q ^ bit_k; ord_wd = k_q;
      end
      CMD_SPLIT_PUSH_P, CMD_SPLIT_PUSH_B, CMD_FREE_PUSH: begin
        if (len_q[k_q] != '0) begin
          next_we = 1'b1; next_a = push_pg; next_wd = head_q[k_q];
          prev_we = 1'b1; prev_a = head_q[k_q]; prev_wd = push_pg;
        end
      end
      CMD_GRANT, CMD_MERGE_B: begin
        ord_we = 1'b1; ord_a = x_q;
      end
      CMD_MERGE_C: ord_we = 1'b1;
      CMD_FREE_FIN: begin
        ord_we = 1'b1; ord_wd = k_q;
      end
      default: ;
    endcase
  end

  // single-port memories, registered read data
  always_ff @(posedge clk_i) begin
    if (ord_we) ord_mem[ord_a] <= ord_wd;
    else if (ord_re) ord_rd_q <= ord_mem[ord_a];
    if (vld_we) vld_mem[vld_a] <= vld_wd;
    else if (vld_re) vld_rd_q <= vld_mem[vld_a];
    if (next_we) next_mem[next_a] <= next_wd;
    else if (lnk_re) next_rd_q <= next_mem[lnk_a];
    if (prev_we) prev_mem[prev_a] <= prev_wd;
    else if (lnk_re) prev_rd_q <= prev_mem[lnk_a];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        op_q  <= req_i.opcode;
        ord_q <= req_i.block_order;
        cur_q <= req_i.page_idx &
                 ~((PageW'(1) << req_i.block_order) - PageW'(1));
      end
      CMD_ALLOC_INIT: k_q <= srch;
      CMD_RD_TAIL:    x_q <= tail_q[k_q];
      CMD_RD_CUR: begin
        k_q     <= ord_q;
        sweep_q <= '0;
      end
      CMD_SWEEP:       sweep_q <= sweep_q + SwW'(1);
      CMD_RD_BUDDY:    x_q <= buddy;
      CMD_UNLINK: begin
        if (x_q == head_q[k_q]) head_q[k_q] <= next_rd_q;
        if (x_q == tail_q[k_q]) tail_q[k_q] <= prev_rd_q;
      end
      CMD_SPLIT_ORD_P: k_q <= k_q - OrdW'(1);
      CMD_SPLIT_PUSH_P, CMD_SPLIT_PUSH_B, CMD_FREE_PUSH: begin
        head_q[k_q] <= push_pg;
        if (len_q[k_q] == '0) tail_q[k_q] <= push_pg;
      end
      CMD_MERGE_C: begin
        cur_q <= cur_q & ~bit_k;
        k_q   <= k_q + OrdW'(1);
      end
      default: ;
    endcase
    case (cmd_i.op)
      CMD_REPORT: rsp_q <= '{status: cmd_i.code, granted_page: '0, free_page_total: total_q};
      CMD_GRANT:  rsp_q <= '{status: ST_OK, granted_page: x_q, free_page_total: total_sub};
      CMD_FREE_PUSH:
        rsp_q <= '{status: ST_OK, granted_page: '0, free_page_total: total_add};
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      total_q  <= '0;
      kfirst_q <= '0;
      kend_q   <= '0;
      rvalid_q <= 1'b0;
      for (int i = 0; i < OrderCount; i++) len_q[i] <= '0;
    end else begin
      rvalid_q <= (cmd_i.op == CMD_REPORT) || (cmd_i.op == CMD_GRANT) ||
                  (cmd_i.op == CMD_FREE_PUSH);
      if (cmd_i.op == CMD_CLEAR) clr_q <= clr_q + PageW'(1);
      if (cmd_i.op == CMD_GRANT) total_q <= total_sub;
      if (cmd_i.op == CMD_FREE_PUSH) total_q <= total_add;
      case (cmd_i.op)
        CMD_UNLINK: len_q[k_q] <= len_q[k_q] - CntW'(1);
        CMD_SPLIT_PUSH_P, CMD_SPLIT_PUSH_B, CMD_FREE_PUSH:
          len_q[k_q] <= len_q[k_q] + CntW'(1);
        default: ;
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_KERNEL_FIRST: kfirst_q <= cfg_data_i;
          CFG_KERNEL_END:   kend_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign rvalid_o = rvalid_q;
  assign rsp_o    = rsp_q;

endmodule

@@ rtl/core/bpa_checker.sv @@
// port-level checks of the buddy page allocator
// depends on bpa_pkg and buddy_page_allocator_assert.svh; bound to the top
`include "buddy_page_allocator_assert.svh"

module bpa_checker import bpa_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input rsp_t               rsp_o
);

  // an accepted item keeps the block busy
  `BPA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")

  // a result only closes a busy period
  `BPA_ASSERT_IMP(a_result_after_work, result_valid_o, $past(busy), "result without work")

  // only a good allocation grants a page
  `BPA_ASSERT_IMP(a_grant_zero, result_valid_o && rsp_o.status != ST_OK,
                  rsp_o.granted_page == '0, "page granted on failure")

  // the result strobe is one cycle per item
  `BPA_ASSERT_NXT(a_single_strobe, result_valid_o, !result_valid_o, "result repeated")

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
